### rtl/core/ufq_pkg.sv
// Shared commands and memory control types for the deduplicating work queue.
package ufq_pkg;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Control for the one-bit membership memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_bit;
  } ufq_bit_ctl_t;

  // Control for the arrival-order store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ufq_store_ctl_t;

endpackage

### rtl/core/ufq_member_mem.sv
// Membership bitmap memory with a clearing sweep after reset.
module ufq_member_mem #(
  parameter int ID_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ufq_pkg::ufq_bit_ctl_t ctl,
  input  logic [ID_BITS-1:0]    rd_addr,
  input  logic [ID_BITS-1:0]    wr_addr,
  output logic                  rdata,
  output logic                  clearing
);

  localparam int DEPTH = 1 << ID_BITS;

  logic               mem [DEPTH];
  logic [ID_BITS:0]   clr_idx;

  assign clearing = ~clr_idx[ID_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx[ID_BITS-1:0]] <= 1'b0;
    end else if (ctl.wr_en) begin
      mem[wr_addr] <= ctl.wr_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/ufq_order_mem.sv
// Circular store that keeps identifiers in order of arrival.
module ufq_order_mem #(
  parameter int ID_BITS = 10
) (
  input  logic                    clk,
  input  ufq_pkg::ufq_store_ctl_t ctl,
  input  logic [ID_BITS-1:0]      rd_addr,
  input  logic [ID_BITS-1:0]      wr_addr,
  input  logic [ID_BITS-1:0]      wdata,
  output logic [ID_BITS-1:0]      rdata
);

  localparam int DEPTH = 1 << ID_BITS;

  logic [ID_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/unique_fifo_queue.sv
// Top level of the deduplicating first-in first-out work queue.
//
//   channel | handshake          | payload
//   --------+--------------------+----------------------------------------------
//   in      | in_valid/in_stall  | command, item_id
//   out     | out_valid/out_stall| popped_id, queue_was_empty, was_inserted,
//           |                    | entries_waiting
//
// Each transaction first reads the bitmap or the order store, then evaluates
// and writes back. Both memories have registered reads. After reset the
// bitmap is swept to zero while in_stall stays high. A result waits in the
// output register; the next input transaction is taken meanwhile and held in
// evaluation until the register frees.
module unique_fifo_queue #(
  parameter int ID_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [ID_BITS-1:0] item_id,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ID_BITS-1:0] popped_id,
  output logic               queue_was_empty,
  output logic               was_inserted,
  output logic [ID_BITS:0]   entries_waiting
);

  import ufq_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  localparam logic [ID_BITS:0] FULL_COUNT = {1'b1, {ID_BITS{1'b0}}};

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic               cmd_q;
  logic [ID_BITS-1:0] id_q;
  logic [ID_BITS-1:0] head_idx;
  logic [ID_BITS-1:0] tail_idx;
  logic [ID_BITS:0]   count;

  ufq_bit_ctl_t       bit_ctl;
  ufq_store_ctl_t     store_ctl;
  logic [ID_BITS-1:0] bit_wr_addr;
  logic               member_rdata;
  logic               clearing;
  logic [ID_BITS-1:0] order_rdata;

  logic accept;
  logic done;
  logic is_push;
  logic do_insert;
  logic pop_empty;
  logic do_pop;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign done      = (state == ST_EXEC) && (!out_valid || !out_stall);
  assign is_push   = (cmd_q == CMD_PUSH);
  assign do_insert = is_push && !member_rdata && (count != FULL_COUNT);
  assign pop_empty = !is_push && (count == '0);
  assign do_pop    = !is_push && (count != '0);

  always_comb begin
    bit_ctl.rd_en    = accept && (command == CMD_PUSH);
    bit_ctl.wr_en    = done && (do_insert || do_pop);
    bit_ctl.wr_bit   = is_push;
    bit_wr_addr      = is_push ? id_q : order_rdata;
    store_ctl.rd_en  = accept && (command == CMD_POP);
    store_ctl.wr_en  = done && do_insert;
  end

  ufq_member_mem #(.ID_BITS(ID_BITS)) u_member (
    .clk      (clk),
    .rst      (rst),
    .ctl      (bit_ctl),
    .rd_addr  (item_id),
    .wr_addr  (bit_wr_addr),
    .rdata    (member_rdata),
    .clearing (clearing)
  );

  ufq_order_mem #(.ID_BITS(ID_BITS)) u_order (
    .clk     (clk),
    .ctl     (store_ctl),
    .rd_addr (head_idx),
    .wr_addr (tail_idx),
    .wdata   (id_q),
    .rdata   (order_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (!clearing) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_EXEC;
      ST_EXEC:  if (done) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      head_idx  <= '0;
      tail_idx  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= done || (out_valid && out_stall);
      if (done && do_insert) begin
        tail_idx <= tail_idx + 1'b1;
        count    <= count + 1'b1;
      end else if (done && do_pop) begin
        head_idx <= head_idx + 1'b1;
        count    <= count - 1'b1;
      end
    end
  end

  // Hold the transaction while its memory read is in flight.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
      id_q  <= item_id;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      popped_id       <= do_pop ? order_rdata : '0;
      queue_was_empty <= pop_empty;
      was_inserted    <= do_insert;
      if (do_insert) begin
        entries_waiting <= count + 1'b1;
      end else if (do_pop) begin
        entries_waiting <= count - 1'b1;
      end else begin
        entries_waiting <= count;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("fill count above depth");

  a_ring_span: assert property (@(posedge clk) disable iff (rst)
    (tail_idx - head_idx) == count[ID_BITS-1:0])
    else $error("head and tail disagree with fill count");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(queue_was_empty && was_inserted))
    else $error("empty and inserted flags both set");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && queue_was_empty) |-> (popped_id == '0))
    else $error("empty pop returned nonzero identifier");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (done && do_insert) |=> (count == $past(count) + 1'b1))
    else $error("insert did not advance fill count");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> in_stall)
    else $error("transaction taken during bitmap sweep");
`endif

endmodule
